// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the i2c master byte sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [15:0] DELAY_RESET = 16'd125;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] cmd;
    logic [7:0] wdata;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       rdata_valid;
  } out_item_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic       is_cmd;
    cmd_t       cmd;
    logic [7:0] shift_init;
    logic       send_ack;
    logic       sda_in;
  } job_t;

endpackage

// File: rtl/i2cms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front
// Decodes each incoming tick into a job for the bus engine.
// ----------------------------------------------------------------------------
module i2cms_front import i2cms_pkg::*; (
  input  in_item_t item,
  output job_t     job
);

  cmd_t cmd;

  assign cmd = cmd_t'(item.cmd);

  always_comb begin
    job.is_cmd     = item.cmd_valid;
    job.cmd        = cmd;
    // only a write preloads the shifter
    job.shift_init = (cmd == CMD_WRITE) ? item.wdata : 8'd0;
    job.send_ack   = item.send_ack;
    job.sda_in     = item.sda_in;
  end

endmodule

// File: rtl/i2cms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_queue
// Small first-in first-out buffer of jobs between front and back.
// ----------------------------------------------------------------------------
module i2cms_queue import i2cms_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nempty,
  output job_t pop_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  assign full    = (count_r == CntW'(DEPTH));
  assign nempty  = (count_r != '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/i2cms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_back
// Bus engine: steps through the pin sequence one job per cycle unless out_stall
// holds a waiting result, and holds each result in an output register.
// ----------------------------------------------------------------------------
module i2cms_back import i2cms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] delay_ticks,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
  } pins_t;

  cmd_t        cmd_r, cmd_nxt;
  logic        running_r, running_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] dc_r, dc_nxt;
  logic        ack_r, ack_nxt;
  logic [7:0]  rdata_r, rdata_nxt;
  pins_t       pins_r, pins_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic [15:0] dc_inc;
  logic        do_enter;
  logic        fin;
  logic        done;
  logic        rvalid;

  // pin actions on entering a step
  function automatic pins_t enter_step(input cmd_t c, input logic [1:0] st,
                                       input logic [3:0] bc, input pins_t p,
                                       input logic ackh);
    pins_t r;
    r = p;
    case (c)
      CMD_START: begin
        if (st == 2'd0) r.sda = 1'b1;
        else if (st == 2'd1) r.scl = 1'b1;
        else if (st == 2'd2) r.sda = 1'b0;
        else r.scl = 1'b0;
      end
      CMD_STOP: begin
        if (st == 2'd0) r.scl = 1'b0;
        else if (st == 2'd1) r.sda = 1'b0;
        else if (st == 2'd2) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      CMD_WRITE: begin
        if (st == 2'd0) begin
          // first bit leaves scl as it is
          if (bc != 4'd0) r.scl = 1'b0;
          if (bc < 4'd8) begin
            r.sda   = p.shift[7];
            r.shift = {p.shift[6:0], 1'b0};
          end else begin
            r.sda = 1'b1;
          end
        end else begin
          r.scl = 1'b1;
        end
      end
      default: begin
        if (bc < 4'd8) begin
          if (st == 2'd0) begin
            if (bc == 4'd0) r.sda = 1'b1;
            r.scl = 1'b1;
          end else begin
            r.scl = 1'b0;
          end
        end else begin
          if (st == 2'd0) r.sda = ~ackh;
          else if (st == 2'd1) r.scl = 1'b1;
          else r.scl = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  assign job_take  = job_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cmd_nxt     = cmd_r;
    running_nxt = running_r;
    step_nxt    = step_r;
    bit_nxt     = bit_r;
    dc_nxt      = dc_r;
    ack_nxt     = ack_r;
    rdata_nxt   = rdata_r;
    pins_nxt    = pins_r;
    do_enter    = 1'b0;
    fin         = 1'b0;
    done        = 1'b0;
    rvalid      = 1'b0;
    dc_inc      = (dc_r != 16'hFFFF) ? dc_r + 16'd1 : dc_r;

    if (running_r) begin
      if (dc_inc >= delay_ticks) begin
        dc_nxt = '0;
        case (cmd_r)
          CMD_START, CMD_STOP: begin
            if (step_r != 2'd3) begin
              step_nxt = step_r + 2'd1;
              do_enter = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (step_r == 2'd0) begin
              step_nxt = 2'd1;
              do_enter = 1'b1;
            end else if (bit_r < 4'd8) begin
              bit_nxt  = bit_r + 4'd1;
              step_nxt = 2'd0;
              do_enter = 1'b1;
            end else begin
              pins_nxt.scl = 1'b0;
              fin          = 1'b1;
            end
          end
          default: begin
            if (bit_r < 4'd8) begin
              // sample at the end of the scl-high step
              if (step_r == 2'd0) begin
                pins_nxt.shift = {pins_r.shift[6:0], job.sda_in};
                step_nxt       = 2'd1;
              end else begin
                bit_nxt  = bit_r + 4'd1;
                step_nxt = 2'd0;
              end
              do_enter = 1'b1;
            end else if (step_r < 2'd2) begin
              step_nxt = step_r + 2'd1;
              do_enter = 1'b1;
            end else begin
              pins_nxt.sda = 1'b1;
              fin          = 1'b1;
            end
          end
        endcase
        if (do_enter) begin
          pins_nxt = enter_step(cmd_r, step_nxt, bit_nxt, pins_nxt, ack_r);
        end
        if (fin) begin
          running_nxt = 1'b0;
          done        = 1'b1;
          if (cmd_r == CMD_READ) begin
            rdata_nxt = pins_nxt.shift;
            rvalid    = 1'b1;
          end
        end
      end else begin
        dc_nxt = dc_inc;
      end
    end else if (job.is_cmd) begin
      cmd_nxt        = job.cmd;
      running_nxt    = 1'b1;
      step_nxt       = 2'd0;
      bit_nxt        = 4'd0;
      dc_nxt         = '0;
      ack_nxt        = job.send_ack;
      pins_nxt.shift = job.shift_init;
      pins_nxt       = enter_step(job.cmd, 2'd0, 4'd0, pins_nxt, job.send_ack);
    end

    out_data_nxt.scl_out     = pins_nxt.scl;
    out_data_nxt.sda_out     = pins_nxt.sda;
    out_data_nxt.busy_res    = running_nxt;
    out_data_nxt.done_res    = done;
    out_data_nxt.rdata       = rdata_nxt;
    out_data_nxt.rdata_valid = rvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= CMD_START;
      running_r   <= 1'b0;
      step_r      <= '0;
      bit_r       <= '0;
      dc_r        <= '0;
      ack_r       <= 1'b0;
      rdata_r     <= '0;
      pins_r      <= '{scl: 1'b1, sda: 1'b1, shift: 8'd0};
      out_valid_r <= 1'b0;
    end else begin
      if (job_take) begin
        cmd_r     <= cmd_nxt;
        running_r <= running_nxt;
        step_r    <= step_nxt;
        bit_r     <= bit_nxt;
        dc_r      <= dc_nxt;
        ack_r     <= ack_nxt;
        rdata_r   <= rdata_nxt;
        pins_r    <= pins_nxt;
      end
      if (job_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/i2c_master_byte_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// I2C master that walks open-drain SCL/SDA through start, stop, write and
// read sequences, one bus tick per item, with a programmable step length.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_item_t, one bus tick
//  out_    | output    | out_valid/out_stall | out_item_t, one per tick
//  cfg_    | input     | cfg_valid/cfg_ready | delay_ticks, 16 bits
//
//  one item per cycle sustained while out_stall is low; each item is decoded
//  into the job queue, then the bus engine writes the output register
//  the engine takes one job a cycle while out_stall is low; the job queue of
//  QUEUE_DEPTH entries lets input keep flowing while a result waits on out_stall
//  synchronous active-low reset: both lines released, delay_ticks = 125
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer import i2cms_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] delay_ticks_r;
  job_t        front_job;
  job_t        q_job;
  logic        q_full;
  logic        q_nempty;
  logic        q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_ticks_r <= cfg_data;
    end
  end

  i2cms_front u_front (
    .item (in_data),
    .job  (front_job)
  );

  i2cms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !q_full),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .nempty   (q_nempty),
    .pop_job  (q_job)
  );

  i2cms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .delay_ticks (delay_ticks_r),
    .job_valid   (q_nempty),
    .job         (q_job),
    .job_take    (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: rtl/i2cms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks of the i2c master byte sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cms_checker import i2cms_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result stays put
  `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // a finishing command is no longer busy
  `ASSERT_NEVER(a_done_not_busy, clk, rst_n, out_valid && out_data.done_res && out_data.busy_res, "done while busy")

  // read data is flagged only when a command finishes
  `ASSERT_NEVER(a_rvalid_done, clk, rst_n, out_valid && out_data.rdata_valid && !out_data.done_res, "rdata_valid without done")

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/i2c_master_byte_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_tb
// Feeds bus ticks and commands into the i2c master and checks every pin and
// status item against a tick-accurate model of the start, stop, write and
// read sequences, over several step lengths and with random idling on both
// channels.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_tb;
  import i2cms_pkg::*;

  localparam int HANG_LIMIT  = 2000;
  localparam int PHASE_TICKS = 150;
  localparam int TOTAL_TICKS = 1500;
  localparam int PRINT_LIMIT = 100;

  localparam out_item_t LINES_IDLE = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam out_item_t LINES_HELD = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

  typedef struct {
    bit          do_cfg;
    logic [15:0] cfg_val;
    in_item_t    tick;
    int          reps;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  bit        gaps_on = 1'b1;
  int        mismatches = 0;
  int        live_ticks = 0;
  int        quiet_cycles = 0;
  out_item_t pending_bus_items[$];
  out_item_t head_item;

  // bus sequencer model
  logic [15:0] step_len = DELAY_RESET;
  cmd_t        bus_cmd = CMD_START;
  logic        bus_running = 1'b0;
  logic [2:0]  phase_step = '0;
  logic [3:0]  bit_idx = '0;
  logic [7:0]  shifter = '0;
  logic [15:0] tick_cnt = '0;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;
  logic        ack_drive = 1'b0;
  logic [7:0]  held_byte = '0;

  plan_row_t plan [14] = '{
    '{1'b0, 16'd0, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 1, 1'b1, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b0, CMD_READ,  8'hFF, 1'b1, 1'b1}, 1, 1'b1, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 1, 1'b1, LINES_HELD},
    // offered while busy, dropped
    '{1'b0, 16'd0, '{1'b1, CMD_READ,  8'hFF, 1'b1, 1'b1}, 1, 1'b1, LINES_HELD},
    // zero step length behaves as one tick
    '{1'b1, 16'd0, '0, 0, 1'b0, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 4, 1'b0, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b1, CMD_STOP,  8'h00, 1'b0, 1'b0}, 1, 1'b0, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 4, 1'b0, LINES_IDLE},
    // first data bit only moves sda, scl stays released
    '{1'b0, 16'd0, '{1'b1, CMD_WRITE, 8'h7F, 1'b0, 1'b0}, 1, 1'b0, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b1}, 5, 1'b0, LINES_IDLE},
    '{1'b1, 16'hFFFF, '0, 0, 1'b0, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b0, CMD_STOP,  8'h00, 1'b1, 1'b0}, 3, 1'b0, LINES_IDLE},
    // count already beyond the new length, step closes on the next tick
    '{1'b1, 16'd1, '0, 0, 1'b0, LINES_IDLE},
    '{1'b0, 16'd0, '{1'b0, CMD_WRITE, 8'h00, 1'b0, 1'b1}, 2, 1'b0, LINES_IDLE}
  };

  i2c_master_byte_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // pin actions on entering the current step
  function automatic void enter_phase();
    case (bus_cmd)
      CMD_START: begin
        case (phase_step)
          3'd0: sda_lvl = 1'b1;
          3'd1: scl_lvl = 1'b1;
          3'd2: sda_lvl = 1'b0;
          default: scl_lvl = 1'b0;
        endcase
      end
      CMD_STOP: begin
        case (phase_step)
          3'd0: scl_lvl = 1'b0;
          3'd1: sda_lvl = 1'b0;
          3'd2: scl_lvl = 1'b1;
          default: sda_lvl = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        if (phase_step == 3'd0) begin
          if (bit_idx != 4'd0) scl_lvl = 1'b0;
          if (bit_idx < 4'd8) begin
            sda_lvl = shifter[7];
            shifter = {shifter[6:0], 1'b0};
          end else begin
            sda_lvl = 1'b1;
          end
        end else begin
          scl_lvl = 1'b1;
        end
      end
      default: begin
        if (bit_idx < 4'd8) begin
          if (phase_step == 3'd0) begin
            if (bit_idx == 4'd0) sda_lvl = 1'b1;
            scl_lvl = 1'b1;
          end else begin
            scl_lvl = 1'b0;
          end
        end else begin
          case (phase_step)
            3'd0: sda_lvl = ack_drive ? 1'b0 : 1'b1;
            3'd1: scl_lvl = 1'b1;
            default: scl_lvl = 1'b0;
          endcase
        end
      end
    endcase
  endfunction

  function automatic out_item_t predict_bus_tick(in_item_t it);
    out_item_t r;
    logic      finished;
    r = '0;
    finished = 1'b0;
    if (bus_running) begin
      if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= step_len) begin
        tick_cnt = '0;
        case (bus_cmd)
          CMD_START, CMD_STOP: begin
            if (phase_step < 3'd3) begin
              phase_step = phase_step + 3'd1;
              enter_phase();
            end else begin
              finished = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_step == 3'd0) begin
              phase_step = 3'd1;
              enter_phase();
            end else if (bit_idx < 4'd8) begin
              bit_idx = bit_idx + 4'd1;
              phase_step = 3'd0;
              enter_phase();
            end else begin
              scl_lvl = 1'b0;
              finished = 1'b1;
            end
          end
          default: begin
            if (bit_idx < 4'd8) begin
              // sample at the end of the scl high step
              if (phase_step == 3'd0) begin
                shifter = {shifter[6:0], it.sda_in};
                phase_step = 3'd1;
              end else begin
                bit_idx = bit_idx + 4'd1;
                phase_step = 3'd0;
              end
              enter_phase();
            end else if (phase_step < 3'd2) begin
              phase_step = phase_step + 3'd1;
              enter_phase();
            end else begin
              sda_lvl = 1'b1;
              finished = 1'b1;
            end
          end
        endcase
        if (finished) begin
          bus_running = 1'b0;
          r.done_res = 1'b1;
          if (bus_cmd == CMD_READ) begin
            held_byte = shifter;
            r.rdata_valid = 1'b1;
          end
        end
      end
    end else if (it.cmd_valid) begin
      bus_cmd = cmd_t'(it.cmd);
      bus_running = 1'b1;
      phase_step = '0;
      bit_idx = '0;
      tick_cnt = '0;
      ack_drive = it.send_ack;
      shifter = (bus_cmd == CMD_WRITE) ? it.wdata : 8'h00;
      enter_phase();
    end
    r.scl_out = scl_lvl;
    r.sda_out = sda_lvl;
    r.busy_res = bus_running;
    r.rdata = held_byte;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] want, logic [7:0] got);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic drive_tick(in_item_t it, bit typed, out_item_t want);
    out_item_t model_out;
    bit        was_busy;
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    was_busy = bus_running;
    model_out = predict_bus_tick(it);
    pending_bus_items.push_back(typed ? want : model_out);
    if (was_busy || it.cmd_valid) live_ticks++;
  endtask

  // only written with nothing in flight
  task automatic set_step_len(logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_bus_items.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_len = v;
  endtask

  initial begin
    int       phase_no;
    int       phase_end;
    in_item_t it;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].do_cfg) set_step_len(plan[i].cfg_val);
      else repeat (plan[i].reps) drive_tick(plan[i].tick, plan[i].typed, plan[i].want);
    end
    phase_no = 0;
    while (live_ticks < TOTAL_TICKS) begin
      // a couple of phases run back to back with no idling
      gaps_on = !(phase_no == 3 || phase_no == 4);
      case ($urandom_range(0, 4))
        0: set_step_len(16'd0);
        1: set_step_len(16'd1);
        default: set_step_len(16'($urandom_range(1, 6)));
      endcase
      phase_end = live_ticks + PHASE_TICKS;
      while (live_ticks < phase_end) begin
        it.cmd_valid = ($urandom_range(0, 3) != 0);
        it.cmd = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) it.wdata = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else it.wdata = 8'($urandom);
        it.send_ack = 1'($urandom_range(0, 1));
        it.sda_in = 1'($urandom_range(0, 1));
        drive_tick(it, 1'b0, LINES_IDLE);
      end
      phase_no++;
    end
    in_valid <= 1'b0;
    while (pending_bus_items.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bus_items.size() == 0) begin
        flag_mismatch("unexpected item", 8'h00, out_data.rdata);
      end else begin
        head_item = pending_bus_items.pop_front();
        if (out_data.scl_out !== head_item.scl_out)
          flag_mismatch("scl_out", 8'(head_item.scl_out), 8'(out_data.scl_out));
        if (out_data.sda_out !== head_item.sda_out)
          flag_mismatch("sda_out", 8'(head_item.sda_out), 8'(out_data.sda_out));
        if (out_data.busy_res !== head_item.busy_res)
          flag_mismatch("busy_res", 8'(head_item.busy_res), 8'(out_data.busy_res));
        if (out_data.done_res !== head_item.done_res)
          flag_mismatch("done_res", 8'(head_item.done_res), 8'(out_data.done_res));
        if (out_data.rdata !== head_item.rdata)
          flag_mismatch("rdata", head_item.rdata, out_data.rdata);
        if (out_data.rdata_valid !== head_item.rdata_valid)
          flag_mismatch("rdata_valid", 8'(head_item.rdata_valid),
                        8'(out_data.rdata_valid));
      end
    end
  end

  // hang detection: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == HANG_LIMIT) begin
      $display("timeout, %0d items still expected", pending_bus_items.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
